>>> hdl/stmix_pkg.sv
// ----------------------------------------------------------------------------
// stmix_pkg: shared types and constants of the stereo two-input mixer
// Holds the register index codes, the fixed-point formats and the pan-law
// function that turns a Q2.14 pan value into left and right weights.
// ----------------------------------------------------------------------------
package stmix_pkg;

  // Configuration register indexes.
  localparam int CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-1:0] REG_IN1_LEFT  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_IN1_RIGHT = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_IN2_LEFT  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_IN2_RIGHT = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_OUT_GAIN  = 3'd4;
  localparam int CFG_DATA_W = 32;

  // Fixed-point formats.
  localparam int GAIN_W    = 16;
  localparam int GAIN_FRAC = 12;
  localparam int PAN_W     = 16;
  localparam int WEIGHT_W  = 15;
  localparam int PROD_FRAC = 26;

  localparam logic [GAIN_W-1:0]   GAIN_UNITY = 16'd4096;
  localparam logic [PAN_W-1:0]    PAN_ONE    = 16'd16384;
  localparam logic [PAN_W-1:0]    PAN_TWO    = 16'd32768;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 15'd16384;

  typedef struct packed {
    logic [WEIGHT_W-1:0] left;
    logic [WEIGHT_W-1:0] right;
  } pan_weights_t;

  // Linear pan law. The pan is first saturated at 2.0; the left weight
  // falls from 1.0 above centre, the right weight rises to 1.0 below it.
  function automatic pan_weights_t pan_weights(input logic [PAN_W-1:0] pan);
    logic [PAN_W-1:0] ps;
    logic [PAN_W-1:0] inv;
    pan_weights_t     w;
    ps  = (pan > PAN_TWO) ? PAN_TWO : pan;
    inv = PAN_TWO - ps;
    w.left  = (ps <= PAN_ONE) ? WEIGHT_ONE : inv[WEIGHT_W-1:0];
    w.right = (ps < PAN_ONE) ? ps[WEIGHT_W-1:0] : WEIGHT_ONE;
    return w;
  endfunction

endpackage

>>> hdl/stereo_two_input_mixer.sv
// ----------------------------------------------------------------------------
// stereo_two_input_mixer: two stereo inputs mixed to one stereo output
// A frame accepted at the input passes stages 1 to 9 in order; stage 9
// is the output register from which the consumer takes it.
// Throughput: one frame per cycle, set by the nine-stage multiply and add
// pipeline; each stage stalls only when its successor is full and stalled,
// so bubbles are squeezed out under backpressure.
// Reset (rst, synchronous, active high) empties the pipeline and restores
// unity gains, centre pans and unity output gain.
// ----------------------------------------------------------------------------
module stereo_two_input_mixer #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // Configuration write channel.
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [stmix_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [stmix_pkg::CFG_DATA_W-1:0]     cfg_data,
  // Input frame stream.
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // tdata fields from bit 0 up: in1_left, in1_right, in2_left, in2_right.
  input  logic [((4*SAMPLE_BITS+7)/8)*8-1:0]   s_axis_tdata,
  // Output frame stream.
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // tdata fields from bit 0 up: out_left, out_right.
  output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]   m_axis_tdata
);

  import stmix_pkg::*;

  // Derived widths. A sample times a Q4.12 gain is kept in SB+17 signed
  // bits; times a 15-bit weight it is kept in SB+33, which also holds the four-term
  // sums with room to spare. A clipped magnitude never exceeds
  // MAXV * 2^26, which fits in SB+25 bits.
  localparam int SB      = SAMPLE_BITS;
  localparam int OUT_W   = ((2*SB+7)/8)*8;
  localparam int SGW     = SB + GAIN_W + 1;
  localparam int AW      = SGW + WEIGHT_W + 1;
  localparam int MW      = SB - 1 + PROD_FRAC;
  localparam int TW      = SB - 1 + GAIN_W;
  localparam int UW      = PROD_FRAC + GAIN_W;
  localparam int QW      = SB + 4;
  localparam int NSTG    = 9;

  localparam logic [SB-1:0] MAXV   = {1'b0, {(SB-1){1'b1}}};
  localparam logic [SB-1:0] MOST_NEG = {1'b1, {(SB-1){1'b0}}};
  localparam logic [QW-1:0] MAXV_Q = {{(QW-SB){1'b0}}, MAXV};
  localparam logic [AW-1:0] LIM    = {{(AW-SB){1'b0}}, MAXV} << PROD_FRAC;

  // --------------------------------------------------------------------------
  // Configuration registers. The pan law is applied when a register is
  // written, so the datapath sees ready-made left and right weights.
  // --------------------------------------------------------------------------
  logic [GAIN_W-1:0]   gain [4];
  logic [WEIGHT_W-1:0] wl   [4];
  logic [WEIGHT_W-1:0] wr   [4];
  logic [GAIN_W-1:0]   og;
  pan_weights_t        cfg_w;

  assign cfg_ready = 1'b1;
  assign cfg_w     = pan_weights(cfg_data[CFG_DATA_W-1:GAIN_W]);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < 4; c++) begin
        gain[c] <= GAIN_UNITY;
        wl[c]   <= WEIGHT_ONE;
        wr[c]   <= WEIGHT_ONE;
      end
      og <= GAIN_UNITY;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_addr)
        REG_IN1_LEFT, REG_IN1_RIGHT, REG_IN2_LEFT, REG_IN2_RIGHT: begin
          gain[cfg_addr[1:0]] <= cfg_data[GAIN_W-1:0];
          wl[cfg_addr[1:0]]   <= cfg_w.left;
          wr[cfg_addr[1:0]]   <= cfg_w.right;
        end
        REG_OUT_GAIN: begin
          og <= cfg_data[GAIN_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline flow control. Stage k loads whenever it is empty or the stage
  // after it is loading, so a stall at the output backs up only as far as
  // the first hole in the pipeline.
  // --------------------------------------------------------------------------
  logic [NSTG:1] v;
  logic [NSTG:1] en;
  logic [NSTG:1] v_in;

  assign en[NSTG] = !v[NSTG] || m_axis_tready;
  for (genvar k = 1; k < NSTG; k++) begin : g_en
    assign en[k] = !v[k] || en[k+1];
  end

  assign v_in          = {v[NSTG-1:1], s_axis_tvalid};
  assign s_axis_tready = en[1];
  assign m_axis_tvalid = v[NSTG];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= (v & ~en) | (v_in & en);
    end
  end

  // --------------------------------------------------------------------------
  // Datapath. Index c runs over in1_left, in1_right, in2_left, in2_right;
  // index i over the left (0) and right (1) output.
  // --------------------------------------------------------------------------
  logic signed [SGW-1:0] s1_sg  [4];
  logic signed [AW-1:0]  s2_pl  [4];
  logic signed [AW-1:0]  s2_pr  [4];
  logic signed [AW-1:0]  s3_pa  [2];
  logic signed [AW-1:0]  s3_pb  [2];
  logic signed [AW-1:0]  s4_acc [2];
  logic                  s5_neg [2];
  logic [AW-1:0]         s5_mag [2];
  logic                  s6_neg [2];
  logic [MW-1:0]         s6_mag [2];
  logic                  s7_neg [2];
  logic [TW-1:0]         s7_t   [2];
  logic [UW-1:0]         s7_u   [2];
  logic                  s8_neg [2];
  logic [QW-1:0]         s8_q   [2];
  logic [SB-1:0]         out_s  [2];

  logic [UW:0]           frac_sum [2];
  logic [QW-1:0]         q_next   [2];
  logic [SB-1:0]         q_sat    [2];

  // Stage 1: sample times channel gain.
  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int c = 0; c < 4; c++) begin
        s1_sg[c] <= SGW'($signed(s_axis_tdata[c*SB +: SB]))
                  * SGW'($signed({1'b0, gain[c]}));
      end
    end
  end

  // Stage 2: split by the pan weights.
  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int c = 0; c < 4; c++) begin
        s2_pl[c] <= AW'(s1_sg[c]) * AW'($signed({1'b0, wl[c]}));
        s2_pr[c] <= AW'(s1_sg[c]) * AW'($signed({1'b0, wr[c]}));
      end
    end
  end

  // Stage 3: input-one and input-two partial sums.
  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_pa[0] <= s2_pl[0] + s2_pl[1];
      s3_pb[0] <= s2_pl[2] + s2_pl[3];
      s3_pa[1] <= s2_pr[0] + s2_pr[1];
      s3_pb[1] <= s2_pr[2] + s2_pr[3];
    end
  end

  // Stage 4: full bus sums.
  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int i = 0; i < 2; i++) begin
        s4_acc[i] <= s3_pa[i] + s3_pb[i];
      end
    end
  end

  // Stage 5: sign and magnitude.
  always_ff @(posedge clk) begin
    if (en[5]) begin
      for (int i = 0; i < 2; i++) begin
        s5_neg[i] <= s4_acc[i][AW-1];
        s5_mag[i] <= s4_acc[i][AW-1] ? AW'(-s4_acc[i]) : AW'(s4_acc[i]);
      end
    end
  end

  // Stage 6: clip the magnitude to full scale.
  always_ff @(posedge clk) begin
    if (en[6]) begin
      for (int i = 0; i < 2; i++) begin
        s6_neg[i] <= s5_neg[i];
        s6_mag[i] <= (s5_mag[i] > LIM) ? LIM[MW-1:0] : s5_mag[i][MW-1:0];
      end
    end
  end

  // Stage 7: output gain, split into integer and fraction partial products.
  always_ff @(posedge clk) begin
    if (en[7]) begin
      for (int i = 0; i < 2; i++) begin
        s7_neg[i] <= s6_neg[i];
        s7_t[i]   <= TW'(s6_mag[i][MW-1:PROD_FRAC]) * TW'(og);
        s7_u[i]   <= UW'(s6_mag[i][PROD_FRAC-1:0]) * UW'(og);
      end
    end
  end

  // Stage 8: recombine and drop the fraction (truncation of the magnitude).
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      frac_sum[i] = (UW+1)'({s7_t[i][GAIN_FRAC-1:0], {PROD_FRAC{1'b0}}})
                  + (UW+1)'(s7_u[i]);
      q_next[i]   = QW'(s7_t[i][TW-1:GAIN_FRAC])
                  + QW'(frac_sum[i][UW:PROD_FRAC+GAIN_FRAC]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[8]) begin
      for (int i = 0; i < 2; i++) begin
        s8_neg[i] <= s7_neg[i];
        s8_q[i]   <= q_next[i];
      end
    end
  end

  // Stage 9: saturate and restore the sign; this is the output register.
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      q_sat[i] = (s8_q[i] > MAXV_Q) ? MAXV : s8_q[i][SB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[9]) begin
      for (int i = 0; i < 2; i++) begin
        out_s[i] <= s8_neg[i] ? SB'(-q_sat[i]) : q_sat[i];
      end
    end
  end

  assign m_axis_tdata = OUT_W'({out_s[1], out_s[0]});

`ifndef SYNTH
  // A saturated result never reaches the most negative code.
  a_out_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (out_s[0] != MOST_NEG && out_s[1] != MOST_NEG))
    else $error("mixer output outside the symmetric range");

  // The input side only stalls when every stage is full and the output
  // is held by the consumer.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (v == '1 && !m_axis_tready))
    else $error("input stalled while the pipeline has room");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (v == '0))
    else $error("pipeline not empty after reset");

  // A full final stage that is not taken keeps its valid bit.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (v[NSTG] && !m_axis_tready) |=> v[NSTG])
    else $error("stalled result dropped");
`endif

endmodule
